### hdl/rse_pkg.sv
// Shared types, constants and GF(256) arithmetic for the RS(255,223) encoder.
package rse_pkg;

    // Number of parity bytes and the low byte of the field polynomial x^8+x^7+x^2+x+1
    localparam int NPAR = 32;
    localparam int CNT_W = $clog2(NPAR);
    localparam logic [7:0] GF_POLY_LOW = 8'h87;

    // Generator coefficients G0..G16 as powers of alpha; G(32-j) equals Gj
    localparam logic [7:0] GEN_LOG [0:16] = '{
        8'd0, 8'd249, 8'd59, 8'd66, 8'd4, 8'd43, 8'd126, 8'd251, 8'd97,
        8'd30, 8'd3, 8'd213, 8'd50, 8'd66, 8'd170, 8'd5, 8'd24
    };

    // Control word handed from the top level to every cell
    typedef struct packed {
        logic fold;   // fold the feedback into the parity byte
        logic clear;  // end of frame: parity byte returns to zero
        logic load;   // capture the folded byte for output
        logic shift;  // advance the output chain by one byte
    } rse_ctrl_t;

    // Multiply two field elements, one bit of b per step
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    // Raise alpha to a power; used only to build constant coefficients
    function automatic logic [7:0] gf_alpha(input logic [7:0] k);
        logic [7:0] v;
        v = 8'h01;
        for (int i = 0; i < 255; i++) begin
            if (i < int'(k)) begin
                v = gf_mul(v, 8'h02);
            end
        end
        return v;
    endfunction

endpackage

### hdl/rse_cell.sv
// One parity cell: holds one parity byte and one byte of the output chain.
module rse_cell
    import rse_pkg::*;
#(
    parameter logic [7:0] COEF = 8'h01
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  rse_ctrl_t  ctrl,
    input  logic [7:0] fb,
    input  logic [7:0] up_par,
    input  logic [7:0] up_out,
    output logic [7:0] par,
    output logic [7:0] out_byte
);

    logic [7:0] par_reg;
    logic [7:0] par_next;
    logic [7:0] out_reg;
    logic [7:0] out_next;
    logic [7:0] folded;

    // Fold: neighbour's byte plus feedback times the constant coefficient
    assign folded = up_par ^ gf_mul(fb, COEF);

    // Update parity: fold on every beat, clear at frame end
    always_comb begin
        par_next = par_reg;
        if (ctrl.fold) begin
            par_next = ctrl.clear ? 8'h00 : folded;
        end
    end

    // Load the finished parity or shift toward the output end
    always_comb begin
        out_next = out_reg;
        if (ctrl.load) begin
            out_next = folded;
        end else if (ctrl.shift) begin
            out_next = up_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            par_reg <= '0;
        end else begin
            par_reg <= par_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign par      = par_reg;
    assign out_byte = out_reg;

endmodule

### hdl/reed_solomon_255_223_encoder_core.sv
// Top level of the RS(255,223) encoder: cell chain and output beat control.
// The first parity beat is offered on m_tvalid in the cycle after the end-of-frame beat.
// Throughput: one data beat per cycle; the 32 parity beats leave at one per cycle while m_tready
// is high. An end-of-frame beat waits while the previous frame's parity drains, except during
// its final beat; data beats within a frame are never held. The cell chain sets the rate.
// Reset clears the parity registers and the output valid flag and beat count; output chain bytes keep their value.
module reed_solomon_255_223_encoder_core
    import rse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_frame
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] parity_byte
    output logic       m_tlast    // parity_last
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CNT_W-1:0] out_cnt_reg;
    logic [CNT_W-1:0] out_cnt_next;
    logic             in_acc;
    logic             eof_acc;
    logic             out_acc;
    logic             out_done;
    logic             out_free;
    logic [7:0]       fb;
    rse_ctrl_t        ctrl;
    logic [7:0]       par_w [0:NPAR-1];
    logic [7:0]       out_w [0:NPAR-1];

    // Handshakes; the chain may reload once its last beat leaves
    assign out_acc  = m_tvalid && m_tready;
    assign out_done = out_acc && (out_cnt_reg == CNT_W'(NPAR - 1));
    assign out_free = !out_valid_reg || out_done;
    assign s_tready = out_free || !s_tlast;
    assign in_acc   = s_tvalid && s_tready;
    assign eof_acc  = in_acc && s_tlast;

    // Feedback into every cell
    assign fb = s_tdata ^ par_w[0];

    assign ctrl.fold  = in_acc;
    assign ctrl.clear = eof_acc;
    assign ctrl.load  = eof_acc;
    assign ctrl.shift = out_acc;

    // Build the chain; cell j takes coefficient index j+1 mirrored about the middle
    for (genvar j = 0; j < NPAR; j++) begin : g_cell
        localparam int K = j + 1;
        localparam int G = (K <= NPAR / 2) ? K : NPAR - K;
        localparam logic [7:0] C = gf_alpha(GEN_LOG[G]);
        logic [7:0] up_par;
        logic [7:0] up_out;
        if (j == NPAR - 1) begin : g_end
            assign up_par = 8'h00;
            assign up_out = 8'h00;
        end else begin : g_mid
            assign up_par = par_w[j+1];
            assign up_out = out_w[j+1];
        end
        rse_cell #(
            .COEF(C)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .fb      (fb),
            .up_par  (up_par),
            .up_out  (up_out),
            .par     (par_w[j]),
            .out_byte(out_w[j])
        );
    end

    // Track the parity beats still to deliver
    always_comb begin
        out_valid_next = out_valid_reg;
        out_cnt_next   = out_cnt_reg;
        if (eof_acc) begin
            out_valid_next = 1'b1;
            out_cnt_next   = '0;
        end else if (out_done) begin
            out_valid_next = 1'b0;
        end else if (out_acc) begin
            out_cnt_next = out_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_cnt_reg   <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_w[0];
    assign m_tlast  = (out_cnt_reg == CNT_W'(NPAR - 1));

    // A frame end starts a fresh run of parity beats
    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        eof_acc |=> m_tvalid && (out_cnt_reg == '0))
        else $error("parity run did not start after frame end");

    // The final parity beat empties the chain unless a new frame reloads it
    a_drain_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        out_done && !eof_acc |=> !m_tvalid)
        else $error("output still valid after last parity beat");

    // A non-final parity beat keeps the run going
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && !m_tlast |=> m_tvalid)
        else $error("parity run cut short");

    // The parity register is cleared behind every frame end
    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        eof_acc |=> (par_w[0] == 8'h00) && (par_w[NPAR-1] == 8'h00))
        else $error("parity register not cleared at frame end");

endmodule
